// ----- design/led_matrix_frame_serializer_assert.svh -----
// ---------------------------------------------------------------------------
// led matrix frame serializer assertion macros
// shared concurrent assertion forms, clocked on clk
// ---------------------------------------------------------------------------
`ifndef LED_MATRIX_FRAME_SERIALIZER_ASSERT_SVH
`define LED_MATRIX_FRAME_SERIALIZER_ASSERT_SVH

// checked outside reset only
`define LMFS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define LMFS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/lmfs_pkg.sv -----
// ---------------------------------------------------------------------------
// lmfs_pkg
// field widths shared by the channel interfaces and the serializer
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lmfs_pkg;

  localparam int OP_W   = 4;
  localparam int ROW_W  = 3;
  localparam int COL_W  = 5;
  localparam int WORD_W = 16;
  localparam int ROWS   = 8;

endpackage

// ----- design/lmfs_cmd_if.sv -----
// ---------------------------------------------------------------------------
// lmfs_cmd_if
// command channel: operation, pixel address and value
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lmfs_cmd_if;
  import lmfs_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  column;
  logic [WORD_W-1:0] value;

  modport source (output valid, output operation, output row, output column,
                  output value, input ready);
  modport sink   (input valid, input operation, input row, input column,
                  input value, output ready);
endinterface

// ----- design/lmfs_res_if.sv -----
// ---------------------------------------------------------------------------
// lmfs_res_if
// result channel: driver word or read pixel with framing flags
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lmfs_res_if;
  import lmfs_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] word;
  logic              is_read;
  logic              latch;
  logic              last;

  modport source (output valid, output word, output is_read, output latch,
                  output last, input ready);
  modport sink   (input valid, input word, input is_read, input latch,
                  input last, output ready);
endinterface

// ----- design/lmfs_ram.sv -----
// ---------------------------------------------------------------------------
// lmfs_ram
// generic single-write single-read ram with registered read data
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lmfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/led_matrix_frame_serializer.sv -----
// ---------------------------------------------------------------------------
// led_matrix_frame_serializer
// one-bit 8-row frame buffer for a chain of 8x8 led driver chips, with
// pixel access, whole-buffer edits and serialization into driver words
// ---------------------------------------------------------------------------
//
//   channel | direction | carries
//   --------+-----------+-----------------------------------------------
//   cmd     | in        | operation, row, column, value
//   res     | out       | word, is_read, latch, last
//
// set pixel writes the row back; get pixel answers when the output slot is free
// clear, fill, invert, shift and rotate do one read-modify-write
//   per row through the single read port of the frame ram
// flush and broadcast send one word per cycle through the one-entry output
//   register; a stalled output holds the walk
// reset clears state and the per-row valid bits, so no ram sweep is needed
// a new request is taken while the last result still waits in the output
//
`timescale 1ns / 1ps

module led_matrix_frame_serializer #(
  parameter int MODULES = 4
) (
  input  logic        clk,
  input  logic        rst,
  lmfs_cmd_if.sink    cmd,
  lmfs_res_if.source  res
);
  import lmfs_pkg::*;

  `include "led_matrix_frame_serializer_assert.svh"

  localparam int COLS  = 8 * MODULES;
  localparam int MW    = (MODULES > 1) ? $clog2(MODULES) : 1;
  localparam int RAW   = $clog2(ROWS);

  // operation codes
  localparam logic [OP_W-1:0] OP_SET   = 4'd0;
  localparam logic [OP_W-1:0] OP_GET   = 4'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 4'd2;
  localparam logic [OP_W-1:0] OP_FILL  = 4'd3;
  localparam logic [OP_W-1:0] OP_INV   = 4'd4;
  localparam logic [OP_W-1:0] OP_SHL   = 4'd5;
  localparam logic [OP_W-1:0] OP_SHR   = 4'd6;
  localparam logic [OP_W-1:0] OP_ROTL  = 4'd7;
  localparam logic [OP_W-1:0] OP_ROTR  = 4'd8;
  localparam logic [OP_W-1:0] OP_FLUSH = 4'd9;
  localparam logic [OP_W-1:0] OP_BCAST = 4'd10;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PIX   = 3'd1;
  localparam logic [2:0] S_SWEEP = 3'd2;
  localparam logic [2:0] S_FLUSH = 3'd3;
  localparam logic [2:0] S_BCAST = 3'd4;

  localparam logic [RAW-1:0] ROW_LAST = RAW'(ROWS - 1);
  localparam logic [MW-1:0]  MOD_LAST = MW'(MODULES - 1);

  logic [2:0]        state;
  logic [RAW-1:0]    row_cnt;     // sweep row, or flush output row
  logic [MW-1:0]     mod_cnt;     // module being emitted
  logic [OP_W-1:0]   cur_op;
  logic [ROW_W-1:0]  cur_row;
  logic [COL_W-1:0]  cur_col;
  logic [WORD_W-1:0] cur_value;

  // rows never written since reset read as zero
  logic [ROWS-1:0]   row_valid;
  logic              rd_ok;

  // output register
  logic              out_valid;
  logic [WORD_W-1:0] out_word;
  logic              out_is_read;
  logic              out_latch;
  logic              out_last;

  // ram ports
  logic              ram_wr_en;
  logic [RAW-1:0]    ram_wr_addr;
  logic [COLS-1:0]   ram_wr_data;
  logic              ram_rd_en;
  logic [RAW-1:0]    ram_rd_addr;
  logic [COLS-1:0]   ram_rd_data;

  logic              cmd_acc;
  logic              out_free;
  logic              out_load;
  logic [COLS-1:0]   rd_row;
  logic [COLS-1:0]   pix_sel;
  logic [COLS-1:0]   swept;
  logic [WORD_W-1:0] load_word;
  logic              load_is_read;
  logic              load_latch;
  logic              load_last;

  lmfs_ram #(
    .WIDTH (COLS),
    .DEPTH (ROWS)
  ) u_frame_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign cmd.ready   = (state == S_IDLE);
  assign res.valid   = out_valid;
  assign res.word    = out_word;
  assign res.is_read = out_is_read;
  assign res.latch   = out_latch;
  assign res.last    = out_last;

  assign cmd_acc  = cmd.valid && cmd.ready;
  assign out_free = !out_valid || res.ready;
  assign rd_row   = ram_rd_data & {COLS{rd_ok}};

  // one-hot column select, empty when the column is past the chain width
  always_comb begin
    for (int j = 0; j < COLS; j++) begin
      pix_sel[j] = ({2'b00, cur_col} == 7'(j));
    end
  end

  // per-row edit for the whole-buffer operations
  always_comb begin
    case (cur_op)
      OP_CLEAR: swept = '0;
      OP_FILL:  swept = '1;
      OP_INV:   swept = ~rd_row;
      OP_SHL:   swept = rd_row >> 1;
      OP_SHR:   swept = rd_row << 1;
      OP_ROTL:  swept = {rd_row[0], rd_row[COLS-1:1]};
      OP_ROTR:  swept = {rd_row[COLS-2:0], rd_row[COLS-1]};
      default:  swept = rd_row;
    endcase
  end

  // ram access: the row read now is on the read data in the next cycle and holds until the next read
  always_comb begin
    ram_rd_en   = 1'b0;
    ram_rd_addr = '0;
    ram_wr_en   = 1'b0;
    ram_wr_addr = cur_row;
    ram_wr_data = rd_row;
    case (state)
      S_IDLE: begin
        if (cmd_acc) begin
          ram_rd_en = 1'b1;
          case (cmd.operation)
            OP_SET, OP_GET: ram_rd_addr = cmd.row;
            OP_FLUSH:       ram_rd_addr = ROW_LAST;
            default:        ram_rd_addr = '0;
          endcase
        end
      end
      S_PIX: begin
        if (cur_op == OP_SET) begin
          ram_wr_en   = 1'b1;
          ram_wr_data = (rd_row & ~pix_sel) | (pix_sel & {COLS{cur_value[0]}});
        end
      end
      S_SWEEP: begin
        // write row n while reading row n+1, never the same entry
        ram_wr_en   = 1'b1;
        ram_wr_addr = row_cnt;
        ram_wr_data = swept;
        if (row_cnt != ROW_LAST) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = row_cnt + 1'b1;
        end
      end
      S_FLUSH: begin
        // fetch the next buffer row as the last module word goes out
        if (out_free && mod_cnt == '0 && row_cnt != ROW_LAST) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = ROW_LAST - (row_cnt + 1'b1);
        end
      end
      default: begin
      end
    endcase
  end

  // result to load into the output register
  always_comb begin
    out_load     = 1'b0;
    load_word    = '0;
    load_is_read = 1'b0;
    load_latch   = 1'b0;
    load_last    = 1'b0;
    case (state)
      S_PIX: begin
        if (cur_op == OP_GET && out_free) begin
          out_load     = 1'b1;
          load_word    = {{(WORD_W-1){1'b0}}, |(rd_row & pix_sel)};
          load_is_read = 1'b1;
          load_latch   = 1'b1;
          load_last    = 1'b1;
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          out_load   = 1'b1;
          load_word  = {4'b0000, {1'b0, row_cnt} + 4'd1, rd_row[{mod_cnt, 3'b000} +: 8]};
          load_latch = (mod_cnt == '0);
          load_last  = (mod_cnt == '0) && (row_cnt == ROW_LAST);
        end
      end
      S_BCAST: begin
        if (out_free) begin
          out_load   = 1'b1;
          load_word  = cur_value;
          load_latch = (mod_cnt == MOD_LAST);
          load_last  = (mod_cnt == MOD_LAST);
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      row_valid <= '0;
      out_valid <= 1'b0;
      rd_ok     <= 1'b0;
    end else begin
      if (ram_rd_en) begin
        rd_ok <= row_valid[ram_rd_addr];
      end
      if (ram_wr_en) begin
        row_valid[ram_wr_addr] <= 1'b1;
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (cmd_acc) begin
            row_cnt <= '0;
            case (cmd.operation)
              OP_SET, OP_GET: begin
                state <= S_PIX;
              end
              OP_CLEAR, OP_FILL, OP_INV, OP_SHL, OP_SHR, OP_ROTL, OP_ROTR: begin
                state <= S_SWEEP;
              end
              OP_FLUSH: begin
                state   <= S_FLUSH;
                mod_cnt <= MOD_LAST;
              end
              OP_BCAST: begin
                state   <= S_BCAST;
                mod_cnt <= '0;
              end
              default: begin
                state <= S_IDLE;  // unused codes do nothing
              end
            endcase
          end
        end
        S_PIX: begin
          if (cur_op != OP_GET || out_free) begin
            state <= S_IDLE;
          end
        end
        S_SWEEP: begin
          row_cnt <= row_cnt + 1'b1;
          if (row_cnt == ROW_LAST) begin
            state <= S_IDLE;
          end
        end
        S_FLUSH: begin
          if (out_free) begin
            if (mod_cnt == '0) begin
              mod_cnt <= MOD_LAST;
              row_cnt <= row_cnt + 1'b1;
              if (row_cnt == ROW_LAST) begin
                state <= S_IDLE;
              end
            end else begin
              mod_cnt <= mod_cnt - 1'b1;
            end
          end
        end
        S_BCAST: begin
          if (out_free) begin
            mod_cnt <= mod_cnt + 1'b1;
            if (mod_cnt == MOD_LAST) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // request fields held for the whole operation
  always_ff @(posedge clk) begin
    if (cmd_acc) begin
      cur_op    <= cmd.operation;
      cur_row   <= cmd.row;
      cur_col   <= cmd.column;
      cur_value <= cmd.value;
    end
    if (out_load) begin
      out_word    <= load_word;
      out_is_read <= load_is_read;
      out_latch   <= load_latch;
      out_last    <= load_last;
    end
  end

  `LMFS_ASSERT(a_no_rw_collide, ram_wr_en && ram_rd_en |-> ram_wr_addr != ram_rd_addr, "ram read and write hit the same row")
  `LMFS_ASSERT_ALWAYS(a_reset_clears, $past(rst) |-> row_valid == '0 && !out_valid, "reset left stale frame rows or output")
  `LMFS_ASSERT(a_sweep_ends, state == S_SWEEP && row_cnt == ROW_LAST |=> state == S_IDLE, "row sweep did not end after the last row")
  `LMFS_ASSERT(a_last_latches, out_valid && out_last |-> out_latch, "final result without latch mark")

endmodule

// ----- tb/led_matrix_frame_serializer_tb.sv -----
// ---------------------------------------------------------------------------
// led_matrix_frame_serializer_tb
// drives pixel, whole-buffer, flush and broadcast requests into the frame
// serializer with random gaps and output stalls, keeps its own copy of the
// frame buffer and compares every driver word and read answer in order
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module led_matrix_frame_serializer_tb;
  import lmfs_pkg::*;

  localparam int MODULES = 4;
  localparam int COLS    = 8 * MODULES;

  // request codes as the block decodes them
  typedef enum logic [OP_W-1:0] {
    OP_SET_PIXEL    = 4'd0,
    OP_GET_PIXEL    = 4'd1,
    OP_CLEAR        = 4'd2,
    OP_FILL         = 4'd3,
    OP_INVERT       = 4'd4,
    OP_SHIFT_LEFT   = 4'd5,
    OP_SHIFT_RIGHT  = 4'd6,
    OP_ROTATE_LEFT  = 4'd7,
    OP_ROTATE_RIGHT = 4'd8,
    OP_FLUSH        = 4'd9,
    OP_BROADCAST    = 4'd10,
    OP_UNUSED_LO    = 4'd11,
    OP_UNUSED_HI    = 4'd15
  } lmfs_op_e;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  column;
    logic [WORD_W-1:0] value;
  } lmfs_request_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              is_read;
    logic              latch;
    logic              last;
  } lmfs_word_t;

  // frame buffer copy and the words it owes, oldest first
  class frame_scoreboard;
    logic [COLS-1:0] frame_rows [ROWS];
    lmfs_word_t      owed_words [$];
    int              mismatches;

    function new();
      foreach (frame_rows[r]) frame_rows[r] = '0;
      mismatches = 0;
    endfunction

    function int outstanding();
      return owed_words.size();
    endfunction

    function void owe(logic [WORD_W-1:0] w, logic rd, logic lat, logic lst);
      lmfs_word_t e;
      e.word    = w;
      e.is_read = rd;
      e.latch   = lat;
      e.last    = lst;
      owed_words.push_back(e);
    endfunction

    // apply one accepted request to the frame copy and queue its words
    function void note_request(lmfs_request_t q);
      logic [COLS-1:0] src;
      logic            px;
      case (q.operation)
        OP_SET_PIXEL: begin
          if (int'(q.column) < COLS) frame_rows[q.row][q.column] = q.value[0];
        end
        OP_GET_PIXEL: begin
          px = (int'(q.column) < COLS) ? frame_rows[q.row][q.column] : 1'b0;
          owe({{(WORD_W-1){1'b0}}, px}, 1'b1, 1'b1, 1'b1);
        end
        OP_CLEAR:  foreach (frame_rows[r]) frame_rows[r] = '0;
        OP_FILL:   foreach (frame_rows[r]) frame_rows[r] = '1;
        OP_INVERT: foreach (frame_rows[r]) frame_rows[r] = ~frame_rows[r];
        // column c takes c+1, zero enters at the right end
        OP_SHIFT_LEFT:  foreach (frame_rows[r]) frame_rows[r] = frame_rows[r] >> 1;
        OP_SHIFT_RIGHT: foreach (frame_rows[r]) frame_rows[r] = frame_rows[r] << 1;
        OP_ROTATE_LEFT: begin
          foreach (frame_rows[r])
            frame_rows[r] = {frame_rows[r][0], frame_rows[r][COLS-1:1]};
        end
        OP_ROTATE_RIGHT: begin
          foreach (frame_rows[r])
            frame_rows[r] = {frame_rows[r][COLS-2:0], frame_rows[r][COLS-1]};
        end
        OP_FLUSH: begin
          // row address r+1 carries buffer row 7-r, last module first
          for (int r = 0; r < ROWS; r++) begin
            src = frame_rows[ROWS-1-r];
            for (int m = MODULES - 1; m >= 0; m--) begin
              owe({4'b0000, 4'(r + 1), src[8*m +: 8]}, 1'b0, m == 0,
                  (m == 0) && (r == ROWS - 1));
            end
          end
        end
        OP_BROADCAST: begin
          for (int m = 0; m < MODULES; m++)
            owe(q.value, 1'b0, m == MODULES - 1, m == MODULES - 1);
        end
        default: ;
      endcase
    endfunction

    function void check_result(lmfs_word_t got);
      lmfs_word_t e;
      if (owed_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result word=%h is_read=%b latch=%b last=%b",
                   $realtime, got.word, got.is_read, got.latch, got.last);
        return;
      end
      e = owed_words.pop_front();
      if (got.word !== e.word || got.is_read !== e.is_read ||
          got.latch !== e.latch || got.last !== e.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch word %h/%h is_read %b/%b latch %b/%b last %b/%b",
                   $realtime, e.word, got.word, e.is_read, got.is_read,
                   e.latch, got.latch, e.last, got.last);
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  lmfs_cmd_if cmd_ch ();
  lmfs_res_if res_ch ();

  led_matrix_frame_serializer #(
    .MODULES (MODULES)
  ) u_top (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  frame_scoreboard sb = new();

  // shared knobs between the request driver and the result sink
  bit no_idle   = 1'b0;   // both sides run back to back
  bit heavy_mix = 1'b0;   // bias toward flush and broadcast
  int long_hold = 0;      // sink holds ready low this many cycles

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #20ms;
    $display("led_matrix_frame_serializer test failed");
    $finish;
  end

  // monitor: requests are noted before results at the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_ch.valid && cmd_ch.ready)
        sb.note_request({cmd_ch.operation, cmd_ch.row, cmd_ch.column, cmd_ch.value});
      if (res_ch.valid && res_ch.ready)
        sb.check_result({res_ch.word, res_ch.is_read, res_ch.latch, res_ch.last});
    end
  end

  // result sink: random stall before each word, plus the long hold-off
  initial begin
    int stall;
    res_ch.ready <= 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (long_hold > 0) begin
        // hold ready low long enough for the output to back up into cmd
        res_ch.ready <= 1'b0;
        repeat (long_hold) @(posedge clk);
        long_hold = 0;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 16);
        if (stall > 0) begin
          res_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      res_ch.ready <= 1'b1;
      // leave early when a hold-off is asked, so an idle output still honors it
      do @(posedge clk); while (!res_ch.valid && long_hold == 0);
    end
  end

  // offer one request after a random gap and wait for it to be taken
  task automatic send_request(input lmfs_request_t q);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.operation <= q.operation;
    cmd_ch.row       <= q.row;
    cmd_ch.column    <= q.column;
    cmd_ch.value     <= q.value;
    do @(posedge clk); while (!cmd_ch.ready);
  endtask

  task automatic send_op(input lmfs_op_e op, input int r, input int c, input int v);
    send_request({op, 3'(r), 5'(c), 16'(v)});
  endtask

  // stop offering, wait for every owed word, then wait out any whole-buffer edit still running
  task automatic drain_results();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
    repeat (12) @(posedge clk);
  endtask

  function automatic lmfs_request_t random_request();
    lmfs_request_t q;
    int pick;
    q.row    = 3'($urandom);
    q.column = 5'($urandom);
    q.value  = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (heavy_mix)
      q.operation = (pick < 60) ? OP_FLUSH : OP_BROADCAST;
    else if (pick < 38) q.operation = OP_SET_PIXEL;
    else if (pick < 58) q.operation = OP_GET_PIXEL;
    else if (pick < 80) q.operation = 4'($urandom_range(OP_CLEAR, OP_ROTATE_RIGHT));
    else if (pick < 87) q.operation = OP_FLUSH;
    else if (pick < 94) q.operation = OP_BROADCAST;
    else                q.operation = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    // fill rarely, so a lit buffer does not swamp the pixel traffic
    if (q.operation == OP_FILL && $urandom_range(0, 1)) q.operation = OP_INVERT;
    return q;
  endfunction

  initial begin
    lmfs_request_t q;
    int counted;
    rst              <= 1'b1;
    cmd_ch.valid     <= 1'b0;
    cmd_ch.operation <= '0;
    cmd_ch.row       <= '0;
    cmd_ch.column    <= '0;
    cmd_ch.value     <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // corner and middle pixels, bit 0 only of value matters
    send_op(OP_SET_PIXEL, 0, 0, 1);
    send_op(OP_SET_PIXEL, 7, COLS - 1, 16'hFFFF);
    send_op(OP_SET_PIXEL, 5, 16, 16'hFFFE);
    send_op(OP_GET_PIXEL, 0, 0, 0);
    send_op(OP_GET_PIXEL, 7, COLS - 1, 0);
    send_op(OP_FLUSH, 0, 0, 0);
    // rotation wraps column 0 to the far end and back
    send_op(OP_ROTATE_LEFT, 0, 0, 0);
    send_op(OP_GET_PIXEL, 0, COLS - 1, 0);
    send_op(OP_ROTATE_RIGHT, 0, 0, 0);
    // shift left drops column 0 and zero fills
    send_op(OP_SHIFT_LEFT, 0, 0, 0);
    send_op(OP_GET_PIXEL, 0, 0, 0);
    send_op(OP_SHIFT_RIGHT, 0, 0, 0);
    send_op(OP_FLUSH, 0, 0, 0);
    send_op(OP_FILL, 0, 0, 0);
    send_op(OP_GET_PIXEL, 4, 9, 0);
    send_op(OP_INVERT, 0, 0, 0);
    send_op(OP_SET_PIXEL, 2, 13, 1);
    send_op(OP_FLUSH, 0, 0, 0);
    send_op(OP_BROADCAST, 0, 0, 16'h0000);
    send_op(OP_BROADCAST, 7, COLS - 1, 16'hFFFF);
    // unused codes change nothing
    send_request({OP_UNUSED_LO, 3'($urandom), 5'($urandom), 16'($urandom)});
    send_request({OP_UNUSED_HI, 3'($urandom), 5'($urandom), 16'($urandom)});
    send_op(OP_CLEAR, 0, 0, 0);
    send_op(OP_GET_PIXEL, 2, 13, 0);
    send_op(OP_FLUSH, 0, 0, 0);
    drain_results();

    // random traffic in four phases of 120 counted requests each
    for (int phase = 0; phase < 4; phase++) begin
      no_idle = (phase == 1);
      if (phase == 2) begin
        // output backs up while flushes and broadcasts keep coming
        long_hold = 400;
        heavy_mix = 1'b1;
      end
      counted = 0;
      while (counted < 120) begin
        if (phase == 2 && counted == 20) heavy_mix = 1'b0;
        q = random_request();
        send_request(q);
        if (q.operation <= OP_BROADCAST) counted++;
        // occasional full pause until every owed word is out
        if ($urandom_range(0, 99) < 3) drain_results();
      end
      drain_results();
    end

    if (sb.mismatches == 0 && sb.outstanding() == 0)
      $display("led_matrix_frame_serializer test passed");
    else
      $display("led_matrix_frame_serializer test failed");
    $finish;
  end

endmodule
